@@ sv/fssm_pkg.sv @@
// ----------------------------------------------------------------------------
// fssm_pkg
// Shared types, constants and helpers of the flex sensor servo mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package fssm_pkg;

  localparam int NUM_CH = 6;

  localparam logic MODE_GLOVE = 1'b0;
  localparam logic MODE_JOY   = 1'b1;

  localparam logic [2:0] SERVO_THUMB  = 3'd0;
  localparam logic [2:0] SERVO_INDEX  = 3'd1;
  localparam logic [2:0] SERVO_MIDDLE = 3'd2;
  localparam logic [2:0] SERVO_RING   = 3'd3;
  localparam logic [2:0] SERVO_PINKY  = 3'd4;
  localparam logic [2:0] SERVO_ROTATE = 3'd6;

  localparam logic [2:0] BEAT_ROTATE = 3'd0;
  localparam logic [2:0] BEAT_LAST   = 3'd6;

  // floor(x/6) = (x * AVG_RECIP) >> 20 for x below 24576
  localparam logic [17:0] AVG_RECIP = 18'd174763;
  // floor(x/25) = (x * DIV25_RECIP) >> 30 for x below 2^25
  localparam logic [25:0] DIV25_RECIP = 26'd42949673;

  localparam logic [27:0] JOY_BASE = 28'd35840000;
  localparam logic [18:0] JOY_GAIN = 19'd391875;

  localparam logic [10:0] ROT_GAIN   = 11'd1056;
  localparam logic [17:0] ROT_OFFSET = 18'd70000;

  typedef logic signed [19:0] slope_t;
  typedef logic signed [32:0] offset_t;
  typedef logic [19:0]        pulse_t;
  typedef pulse_t             pulse_arr_t [NUM_CH];

  localparam slope_t CH_SLOPE [NUM_CH] = '{
    -20'sd430839, -20'sd311475, -20'sd395833, -20'sd380000, -20'sd287878, -20'sd380000
  };

  // channel offsets pre-scaled by 1600
  localparam offset_t CH_OFFSET [NUM_CH] = '{
    33'sd1481035200, 33'sd1120288000, 33'sd1435665600,
    33'sd1388800000, 33'sd1083876800, 33'sd1609600000
  };

  typedef struct packed {
    logic       mode;
    logic [2:0] sel;
    pulse_t     rot;
    pulse_t     joy;
  } side_t;

  function automatic logic [2:0] next_servo(input logic [2:0] s);
    logic [2:0] n;
    unique case (s)
      SERVO_THUMB:  n = SERVO_INDEX;
      SERVO_INDEX:  n = SERVO_MIDDLE;
      SERVO_MIDDLE: n = SERVO_RING;
      SERVO_RING:   n = SERVO_PINKY;
      SERVO_PINKY:  n = SERVO_ROTATE;
      default:      n = SERVO_THUMB;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ sv/fssm_lane.sv @@
// ----------------------------------------------------------------------------
// fssm_lane
// One sensor channel: six-tap moving average and linear map to a pulse count.
// ----------------------------------------------------------------------------
`default_nettype none

module fssm_lane (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              load,
  input  wire logic [11:0]       sample,
  input  wire fssm_pkg::slope_t  slope,
  input  wire fssm_pkg::offset_t offset,
  output fssm_pkg::pulse_t       pulse
);

  logic [11:0]        hist [5];
  logic [14:0]        sum;
  logic [11:0]        avg;
  logic signed [32:0] prod;
  logic [24:0]        quo;

  logic [32:0]        avg_mul;
  logic signed [32:0] num;
  logic [50:0]        div_mul;

  assign avg_mul = {18'd0, sum} * {15'd0, fssm_pkg::AVG_RECIP};
  assign num     = offset + prod;
  assign div_mul = {26'd0, quo} * {25'd0, fssm_pkg::DIV25_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 5; k++) hist[k] <= '0;
    end else if (load) begin
      hist[0] <= sample;
      for (int k = 1; k < 5; k++) hist[k] <= hist[k-1];
    end
  end

  // five-stage datapath, advancing with the top-level pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      sum   <= 15'(sample) + 15'(hist[0]) + 15'(hist[1]) + 15'(hist[2])
             + 15'(hist[3]) + 15'(hist[4]);
      avg   <= avg_mul[31:20];
      prod  <= 33'(slope) * $signed({21'd0, avg});
      quo   <= (num <= 0) ? '0 : num[30:6];
      pulse <= div_mul[49:30];
    end
  end

endmodule

`default_nettype wire

@@ sv/fssm_merge.sv @@
// ----------------------------------------------------------------------------
// fssm_merge
// Gathers the lane results of one tick and sends them out one beat per cycle while m_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module fssm_merge (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire fssm_pkg::pulse_arr_t in_pulse,
  input  wire fssm_pkg::side_t      in_side,
  output logic                      m_valid,
  input  wire logic                 m_ready,
  output logic [2:0]                m_servo,
  output fssm_pkg::pulse_t          m_pulse,
  output logic                      m_last
);

  logic                 bvalid;
  logic [2:0]           cnt;
  fssm_pkg::pulse_arr_t pulses;
  fssm_pkg::side_t      side;

  logic             out_load;
  logic             emit;
  logic             done;
  logic             take;
  logic [2:0]       ch;
  logic [2:0]       beat_servo;
  fssm_pkg::pulse_t beat_pulse;
  logic             beat_last;

  assign out_load = !m_valid || m_ready;
  assign emit     = bvalid && out_load;
  assign done     = emit && (side.mode == fssm_pkg::MODE_JOY || cnt == fssm_pkg::BEAT_LAST);
  assign in_ready = !bvalid || done;
  assign take     = in_valid && in_ready;
  assign ch       = cnt - 3'd1;

  always_comb begin
    if (side.mode == fssm_pkg::MODE_JOY) begin
      beat_servo = side.sel;
      beat_pulse = side.joy;
      beat_last  = 1'b1;
    end else if (cnt == fssm_pkg::BEAT_ROTATE) begin
      beat_servo = fssm_pkg::SERVO_ROTATE;
      beat_pulse = side.rot;
      beat_last  = 1'b0;
    end else begin
      beat_servo = ch;
      beat_pulse = pulses[ch];
      beat_last  = (cnt == fssm_pkg::BEAT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      cnt    <= '0;
    end else if (take) begin
      bvalid <= 1'b1;
      cnt    <= '0;
    end else if (done) begin
      bvalid <= 1'b0;
    end else if (emit) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pulses <= in_pulse;
      side   <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_load) begin
      m_valid <= bvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_servo <= beat_servo;
      m_pulse <= beat_pulse;
      m_last  <= beat_last;
    end
  end

endmodule

`default_nettype wire

@@ sv/flex_sensor_servo_mapper.sv @@
// ----------------------------------------------------------------------------
// flex_sensor_servo_mapper
// Maps flex sensor, tilt and joystick readings to servo pulse counts.
// ----------------------------------------------------------------------------
// One input beat per poll tick on s_axis; servo commands leave on m_axis with
// the servo number in tuser and the pulse count in tdata.
// Glove mode (control_mode 0): seven beats per tick, rotate servo first, then
// channels 0 to 5 from six parallel averaging lanes; tlast on channel 5.
// Joystick mode (control_mode 1): one beat per tick to the selected servo,
// tlast set; a button press steps the selection and clears the smoothing.
// An accepted input beat passes the lane pipeline, the merge buffer and the
// output register before the first beat of its tick is valid on m_axis.
// Throughput is set by the output serializer, which emits one beat per cycle
// while m_axis_tready is high.
// Input beats are taken while earlier ticks are still in the lanes or waiting
// in the output register. When m_axis_tready is low the output register holds,
// the lane pipeline fills and s_axis_tready drops.
// Reset clears sample and joystick history, selects the thumb servo and sets
// joystick mode. control_mode is written through cfg_wr_en / cfg_wr_data.
// ----------------------------------------------------------------------------
`default_nettype none

module flex_sensor_servo_mapper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // thumb, index, middle, ring, pinky, bend samples (12 each), tilt_angle (9),
  // joystick_level (8), button_pressed (1), zero fill (6)
  input  wire logic [95:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pulse_count (20), zero fill (4)
  output logic [23:0]      m_axis_tdata,
  // servo_index (3)
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int STAGES = 5;

  logic                 control_mode;
  logic [2:0]           sel;
  logic [18:0]          jhist [3];

  logic                 adv;
  logic                 accept;
  logic                 merge_ready;
  logic [STAGES-1:0]    vld;

  logic [27:0]          jvfx;
  logic [20:0]          jhsum;
  fssm_pkg::side_t      side [STAGES];
  fssm_pkg::pulse_arr_t lane_pulse;

  logic signed [8:0]    tilt;
  logic signed [9:0]    angle;
  logic [7:0]           angle_c;
  logic [17:0]          rot;
  logic [7:0]           level;
  logic                 button;
  logic [2:0]           sel_eff;
  logic [18:0]          jh_eff [3];
  logic [27:0]          vfx_now;
  logic [29:0]          jtotal;
  fssm_pkg::pulse_t     m_pulse;

  assign tilt   = $signed(s_axis_tdata[80:72]);
  assign level  = s_axis_tdata[88:81];
  assign button = s_axis_tdata[89];

  assign adv           = !vld[STAGES-1] || merge_ready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // rotate servo from tilt
  always_comb begin
    angle = 10'sd90 + 10'(tilt);
    if (angle > 10'sd180) begin
      angle_c = 8'd180;
    end else if (angle < 10'sd0) begin
      angle_c = 8'd0;
    end else begin
      angle_c = angle[7:0];
    end
    rot = 18'(angle_c) * 18'(fssm_pkg::ROT_GAIN) + fssm_pkg::ROT_OFFSET;
  end

  // joystick selection and history after a possible button press
  always_comb begin
    sel_eff = button ? fssm_pkg::next_servo(sel) : sel;
    for (int k = 0; k < 3; k++) jh_eff[k] = button ? '0 : jhist[k];
    vfx_now = fssm_pkg::JOY_BASE + 28'(level) * 28'(fssm_pkg::JOY_GAIN);
    jtotal  = 30'(jvfx) + {jhsum, 9'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode <= fssm_pkg::MODE_JOY;
    end else if (cfg_wr_en) begin
      control_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= fssm_pkg::SERVO_THUMB;
      for (int k = 0; k < 3; k++) jhist[k] <= '0;
    end else if (accept && control_mode == fssm_pkg::MODE_JOY) begin
      sel      <= sel_eff;
      jhist[0] <= vfx_now[27:9];
      jhist[1] <= jh_eff[0];
      jhist[2] <= jh_eff[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      jvfx    <= vfx_now;
      jhsum   <= 21'(jh_eff[0]) + 21'(jh_eff[1]) + 21'(jh_eff[2]);
      side[0] <= '{mode: control_mode, sel: sel_eff, rot: 20'(rot), joy: '0};
      side[1] <= '{mode: side[0].mode, sel: side[0].sel, rot: side[0].rot,
                   joy: 20'(jtotal[29:11])};
      for (int k = 2; k < STAGES; k++) side[k] <= side[k-1];
    end
  end

  for (genvar g = 0; g < fssm_pkg::NUM_CH; g++) begin : g_lane
    fssm_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .load   (accept && control_mode == fssm_pkg::MODE_GLOVE),
      .sample (s_axis_tdata[12*g +: 12]),
      .slope  (fssm_pkg::CH_SLOPE[g]),
      .offset (fssm_pkg::CH_OFFSET[g]),
      .pulse  (lane_pulse[g])
    );
  end

  fssm_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[STAGES-1]),
    .in_ready (merge_ready),
    .in_pulse (lane_pulse),
    .in_side  (side[STAGES-1]),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_servo  (m_axis_tuser),
    .m_pulse  (m_pulse),
    .m_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, m_pulse};

endmodule

`default_nettype wire
